[hw/rtl/tgd_pkg.sv]
// shared types, codes and constants of the thresholded graph degree core
package tgd_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int NODE_W    = 6;
  localparam int DEG_W     = 7;
  localparam int NCNT_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [DEG_W-1:0]  DEG_MAX       = '1;
  localparam logic [NCNT_W-1:0] NODE_CNT_RST  = NCNT_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNDIRECTED = 2'd0,
    CFG_NODE_COUNT = 2'd1,
    CFG_LOW_THRESH = 2'd2,
    CFG_HIGH_THRESH = 2'd3
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WRM   = 7'b0000010,
    ST_CLR   = 7'b0000100,
    ST_ACK   = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } acc_ctrl_t;

endpackage

[hw/rtl/tgd_if.sv]
// valid/ready channel interfaces for command beats and result beats
interface tgd_in_if import tgd_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic [NODE_W-1:0]             row;
  logic [NODE_W-1:0]             col;
  logic signed [WEIGHT_BITS-1:0] weight;

  modport source (output valid, cmd, row, col, weight, input ready);
  modport sink (input valid, cmd, row, col, weight, output ready);
endinterface

interface tgd_out_if import tgd_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [NODE_W-1:0]             node;
  logic [DEG_W-1:0]              degree;
  logic signed [WEIGHT_BITS-1:0] smallest;
  logic signed [WEIGHT_BITS-1:0] largest;
  logic                          status;
  logic                          last;

  modport source (output valid, node, degree, smallest, largest, status, last, input ready);
  modport sink (input valid, node, degree, smallest, largest, status, last, output ready);
endinterface

[hw/rtl/tgd_acc.sv]
// window test of one weight and saturating degree counter
module tgd_acc import tgd_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acc_ctrl_t                     ctrl,
  input  logic signed [WEIGHT_BITS-1:0] rd_data,
  input  logic signed [WEIGHT_BITS-1:0] low,
  input  logic signed [WEIGHT_BITS-1:0] high,
  output logic [DEG_W-1:0]              count
);

  logic [DEG_W-1:0] count_r;
  logic [DEG_W-1:0] count_nxt;
  logic             hit;

  assign hit = (rd_data >= low) && (rd_data <= high);

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clr) begin
      count_nxt = '0;
    end else if (ctrl.en && hit && (count_r != DEG_MAX)) begin
      count_nxt = count_r + DEG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

[hw/rtl/thresholded_graph_degree_core.sv]
// Thresholded graph degree core: the weight matrix sits in one simple dual-port synchronous
// memory of MAX_NODES*MAX_NODES entries with a fixed row stride of MAX_NODES. A write
// beat writes its entry (and, in undirected mode, the mirror entry from ST_WRM) and then
// sends its acknowledge beat; an out-of-range write is only acknowledged, with status set.
// A compute beat walks the matrix node by node, one memory read a cycle: the n reads of a
// row in ST_SCAN, then ST_DRAIN for the last read to land and ST_EMIT to hand the result
// over, where an output stall can hold it. A clear beat sweeps every entry through the
// write port, then acknowledges. The same sweep runs after reset without an acknowledge;
// no command beat is taken during it, configuration writes are.
module thresholded_graph_degree_core import tgd_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tgd_in_if.sink                      in_ch,
  tgd_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_idx,
  input  logic [((WEIGHT_BITS > NCNT_W) ? WEIGHT_BITS : NCNT_W)-1:0] cfg_wdata
);

  localparam int MEM_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [ADDR_W-1:0]      STRIDE    = ADDR_W'(MAX_NODES);
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [WEIGHT_BITS-1:0] W_ONE     = WEIGHT_BITS'(1);
  localparam logic [WEIGHT_BITS-1:0] W_MIN     = W_ONE << (WEIGHT_BITS - 1);
  localparam logic [WEIGHT_BITS-1:0] W_MAX     = ~W_MIN;
  localparam logic [WEIGHT_BITS-1:0] HIGH_RST  =
    (WEIGHT_BITS > 16) ? WEIGHT_BITS'(32767) : W_MAX;

  // configuration
  logic                          undir_r;
  logic [NCNT_W-1:0]             node_cnt_r;
  logic signed [WEIGHT_BITS-1:0] low_r;
  logic signed [WEIGHT_BITS-1:0] high_r;

  // control
  state_t                        state_r, state_nxt;
  logic [NCNT_W-1:0]             k_r, k_nxt;
  logic [NCNT_W-1:0]             j_r, j_nxt;
  logic [ADDR_W-1:0]             clr_addr_r, clr_addr_nxt;
  logic                          clr_ack_r, clr_ack_nxt;
  logic                          ack_status_r, ack_status_nxt;
  logic                          rd_pend_r, rd_pend_nxt;
  logic signed [WEIGHT_BITS-1:0] min_r, min_nxt;
  logic signed [WEIGHT_BITS-1:0] max_r, max_nxt;
  logic [ADDR_W-1:0]             mir_addr_r, mir_addr_nxt;
  logic [WEIGHT_BITS-1:0]        mir_data_r, mir_data_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]             out_node_r, out_node_nxt;
  logic [DEG_W-1:0]              out_deg_r, out_deg_nxt;
  logic signed [WEIGHT_BITS-1:0] out_min_r, out_min_nxt;
  logic signed [WEIGHT_BITS-1:0] out_max_r, out_max_nxt;
  logic                          out_status_r, out_status_nxt;
  logic                          out_last_r, out_last_nxt;

  // memory
  logic [WEIGHT_BITS-1:0]        mem [MEM_DEPTH];
  logic [WEIGHT_BITS-1:0]        rd_data_r;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [WEIGHT_BITS-1:0]        mem_wdata;
  logic [ADDR_W-1:0]             mem_raddr;

  logic [NCNT_W-1:0]             n_eff;
  logic [NCNT_W-1:0]             n_last;
  logic                          in_acc;
  logic                          out_free;
  logic                          in_range;
  logic                          lower_half;
  logic [NCNT_W-1:0]             scan_row;
  logic [NCNT_W-1:0]             scan_col;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             wr_mirror;
  logic [ADDR_W-1:0]             scan_addr;
  acc_ctrl_t                     acc_ctrl;
  logic [DEG_W-1:0]              acc_count;

  always_comb begin
    if (node_cnt_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (int'(node_cnt_r) > MAX_NODES) begin
      n_eff = NCNT_W'(MAX_NODES);
    end else begin
      n_eff = node_cnt_r;
    end
  end

  assign n_last   = n_eff - NCNT_W'(1);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_range = (NCNT_W'(in_ch.row) < n_eff) && (NCNT_W'(in_ch.col) < n_eff);

  assign wr_addr   = ADDR_W'(in_ch.row) * STRIDE + ADDR_W'(in_ch.col);
  assign wr_mirror = ADDR_W'(in_ch.col) * STRIDE + ADDR_W'(in_ch.row);

  // undirected scans read (min, max) so only the upper triangle is seen
  assign lower_half = undir_r && (j_r < k_r);
  assign scan_row   = lower_half ? j_r : k_r;
  assign scan_col   = lower_half ? k_r : j_r;
  assign scan_addr  = ADDR_W'(scan_row) * STRIDE + ADDR_W'(scan_col);

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    clr_addr_nxt   = clr_addr_r;
    clr_ack_nxt    = clr_ack_r;
    ack_status_nxt = ack_status_r;
    rd_pend_nxt    = 1'b0;
    min_nxt        = min_r;
    max_nxt        = max_r;
    mir_addr_nxt   = mir_addr_r;
    mir_data_nxt   = mir_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_node_nxt   = out_node_r;
    out_deg_nxt    = out_deg_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr;
    mem_wdata      = in_ch.weight;
    mem_raddr      = scan_addr;
    acc_ctrl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_ch.cmd))
            CMD_WRITE: begin
              if (in_range) begin
                mem_we         = 1'b1;
                mir_addr_nxt   = wr_mirror;
                mir_data_nxt   = in_ch.weight;
                ack_status_nxt = 1'b0;
                if (in_ch.weight < min_r) begin
                  min_nxt = in_ch.weight;
                end
                if (in_ch.weight > max_r) begin
                  max_nxt = in_ch.weight;
                end
                state_nxt = undir_r ? ST_WRM : ST_ACK;
              end else begin
                ack_status_nxt = 1'b1;
                state_nxt      = ST_ACK;
              end
            end
            CMD_COMPUTE: begin
              k_nxt        = '0;
              j_nxt        = '0;
              acc_ctrl.clr = 1'b1;
              state_nxt    = ST_SCAN;
            end
            CMD_CLEAR: begin
              clr_addr_nxt = '0;
              clr_ack_nxt  = 1'b1;
              state_nxt    = ST_CLR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRM: begin
        mem_we    = 1'b1;
        mem_waddr = mir_addr_r;
        mem_wdata = mir_data_r;
        state_nxt = ST_ACK;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          min_nxt        = W_MAX;
          max_nxt        = W_MIN;
          ack_status_nxt = 1'b0;
          state_nxt      = clr_ack_r ? ST_ACK : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = '0;
          out_deg_nxt    = '0;
          out_min_nxt    = min_r;
          out_max_nxt    = max_r;
          out_status_nxt = ack_status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = 1'b1;
        if (j_r == n_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + NCNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = NODE_W'(k_r);
          out_deg_nxt    = acc_count;
          out_min_nxt    = min_r;
          out_max_nxt    = max_r;
          out_status_nxt = 1'b0;
          out_last_nxt   = (k_r == n_last);
          acc_ctrl.clr   = 1'b1;
          if (k_r == n_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + NCNT_W'(1);
            j_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (rd_pend_r) begin
      acc_ctrl.en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  tgd_acc #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (acc_ctrl),
    .rd_data (rd_data_r),
    .low     (low_r),
    .high    (high_r),
    .count   (acc_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      undir_r    <= 1'b0;
      node_cnt_r <= NODE_CNT_RST;
      low_r      <= '0;
      high_r     <= HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_UNDIRECTED:  undir_r    <= cfg_wdata[0];
        CFG_NODE_COUNT:  node_cnt_r <= cfg_wdata[NCNT_W-1:0];
        CFG_LOW_THRESH:  low_r      <= cfg_wdata[WEIGHT_BITS-1:0];
        CFG_HIGH_THRESH: high_r     <= cfg_wdata[WEIGHT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      k_r          <= '0;
      j_r          <= '0;
      clr_addr_r   <= '0;
      clr_ack_r    <= 1'b0;
      ack_status_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      min_r        <= W_MAX;
      max_r        <= W_MIN;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      j_r          <= j_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_ack_r    <= clr_ack_nxt;
      ack_status_r <= ack_status_nxt;
      rd_pend_r    <= rd_pend_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mir_addr_r   <= mir_addr_nxt;
    mir_data_r   <= mir_data_nxt;
    out_node_r   <= out_node_nxt;
    out_deg_r    <= out_deg_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.node     = out_node_r;
  assign out_ch.degree   = out_deg_r;
  assign out_ch.smallest = out_min_r;
  assign out_ch.largest  = out_max_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

endmodule
